FILE: hw/rtl/rsfl_pkg.sv
package rsfl_pkg;

  localparam int unsigned NUM_SLOTS = 1024;
  localparam int unsigned DATA_BITS = 64;

  // Port field widths
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned ID_W    = 10;
  localparam int unsigned WDATA_W = 64;
  localparam int unsigned CNT_W   = 11;

  // Slot index and link widths; a link can also hold NUM_SLOTS (empty list)
  localparam int unsigned SLOT_W = $clog2(NUM_SLOTS);
  localparam int unsigned LINK_W = $clog2(NUM_SLOTS + 1);

  localparam logic [LINK_W-1:0] LINK_EMPTY = LINK_W'(NUM_SLOTS);

  typedef enum logic [FUNC_W-1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_ADD    = 2'd2,
    FUNC_DELETE = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_MISSING = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_CORRUPT = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    func_e               func;
    logic [ID_W-1:0]     record_id;
    logic [WDATA_W-1:0]  write_data;
  } req_t;

  typedef struct packed {
    status_e             status;
    logic [ID_W-1:0]     new_id;
    logic [WDATA_W-1:0]  read_data;
    logic [CNT_W-1:0]    active_count;
  } rsp_t;

  // One memory word per slot
  typedef struct packed {
    logic                 used;
    logic [LINK_W-1:0]    next_free;
    logic [DATA_BITS-1:0] data;
  } slot_entry_t;

  localparam int unsigned ENTRY_W = $bits(slot_entry_t);

endpackage

FILE: hw/rtl/rsfl_ram.sv
module rsfl_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/rsfl_ctrl.sv
module rsfl_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  rsfl_pkg::req_t                in_data_i,
  input  logic                          out_hold_i,
  output logic                          rsp_valid_o,
  output rsfl_pkg::rsp_t                rsp_o,
  output logic                          ram_re_o,
  output logic [rsfl_pkg::SLOT_W-1:0]   ram_raddr_o,
  output logic                          ram_we_o,
  output logic [rsfl_pkg::SLOT_W-1:0]   ram_waddr_o,
  output rsfl_pkg::slot_entry_t         ram_wdata_o,
  input  rsfl_pkg::slot_entry_t         ram_rdata_i
);
  import rsfl_pkg::*;

  state_e state_q, state_d;
  req_t   req_q;
  logic [SLOT_W-1:0] addr_q;
  logic [LINK_W-1:0] head_q, head_d;
  logic [LINK_W-1:0] hw_q, hw_d;
  logic [LINK_W-1:0] used_q, used_d;

  logic accept;
  logic go;
  logic id_ok;
  logic id_used;
  logic head_used;
  logic we;
  slot_entry_t wentry;
  rsp_t rsp;

  // FSM next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_EXEC;
      S_EXEC: if (!out_hold_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_stall_o = 1'b1;
    go         = 1'b0;
    unique case (state_q)
      S_IDLE: in_stall_o = 1'b0;
      S_EXEC: go = !out_hold_i;
      default: ;
    endcase
  end

  assign accept = in_valid_i && !in_stall_o;

  // Read address: the slot named by the request, or the slot an add takes
  always_comb begin
    if (in_data_i.func == FUNC_ADD) begin
      ram_raddr_o = (head_q != LINK_EMPTY) ? SLOT_W'(head_q) : SLOT_W'(hw_q);
    end else begin
      ram_raddr_o = SLOT_W'(in_data_i.record_id);
    end
  end
  assign ram_re_o = accept;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= in_data_i;
      addr_q <= ram_raddr_o;
    end
  end

  // In-use marks at or above the high-water count were never written; they read as clear.
  assign id_ok     = 32'(req_q.record_id) < NUM_SLOTS;
  assign id_used   = id_ok && (32'(req_q.record_id) < 32'(hw_q)) && ram_rdata_i.used;
  assign head_used = (head_q < hw_q) && ram_rdata_i.used;

  always_comb begin
    head_d = head_q;
    hw_d   = hw_q;
    used_d = used_q;
    we     = 1'b0;
    wentry = ram_rdata_i;
    rsp    = '0;
    rsp.status = STAT_OK;
    unique case (req_q.func)
      FUNC_READ: begin
        if (id_used) begin
          rsp.read_data = WDATA_W'(ram_rdata_i.data);
        end else begin
          rsp.status = STAT_MISSING;
        end
      end
      FUNC_WRITE: begin
        if (id_used) begin
          we          = 1'b1;
          wentry.data = req_q.write_data[DATA_BITS-1:0];
        end else begin
          rsp.status = STAT_MISSING;
        end
      end
      FUNC_ADD: begin
        if (head_q != LINK_EMPTY) begin
          if (head_q > LINK_EMPTY || head_used) begin
            rsp.status = STAT_CORRUPT;
          end else begin
            head_d      = ram_rdata_i.next_free;
            we          = 1'b1;
            wentry.used = 1'b1;
            wentry.data = req_q.write_data[DATA_BITS-1:0];
            used_d      = used_q + LINK_W'(1);
            rsp.new_id  = ID_W'(addr_q);
          end
        end else if (hw_q >= LINK_EMPTY) begin
          rsp.status = STAT_FULL;
        end else begin
          hw_d        = hw_q + LINK_W'(1);
          we          = 1'b1;
          wentry.used = 1'b1;
          wentry.data = req_q.write_data[DATA_BITS-1:0];
          used_d      = used_q + LINK_W'(1);
          rsp.new_id  = ID_W'(addr_q);
        end
      end
      FUNC_DELETE: begin
        if (id_used) begin
          we               = 1'b1;
          wentry.used      = 1'b0;
          wentry.next_free = head_q;
          head_d           = LINK_W'(req_q.record_id);
          used_d           = used_q - LINK_W'(1);
        end else begin
          rsp.status = STAT_MISSING;
        end
      end
      default: ;
    endcase
    rsp.active_count = CNT_W'(used_d);
  end

  assign ram_we_o    = go && we;
  assign ram_waddr_o = addr_q;
  assign ram_wdata_o = wentry;
  assign rsp_valid_o = go;
  assign rsp_o       = rsp;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= LINK_EMPTY;
      hw_q    <= '0;
      used_q  <= '0;
    end else begin
      state_q <= state_d;
      if (go) begin
        head_q <= head_d;
        hw_q   <= hw_d;
        used_q <= used_d;
      end
    end
  end

endmodule

FILE: hw/rtl/record_slot_store_free_list_core.sv
// A transfer's slot is read into the memory read register at accept; the result is
//   then registered in the output register once that register is free.
// One operation at a time: the input stalls from accept until the write-back of that slot.
// Reset (async, active low) clears the free-list head, high-water and in-use
//   counts at once; no memory clearing pass is needed before the first request.
module record_slot_store_free_list_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  rsfl_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output rsfl_pkg::rsp_t out_data_o
);
  import rsfl_pkg::*;

  // Slot memory: one word per slot holds in-use mark, free-list link and data.
  // Slots at or above the high-water count were never taken, so their marks
  // are treated as clear no matter what the memory holds.
  logic              ram_re;
  logic [SLOT_W-1:0] ram_raddr;
  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  slot_entry_t       ram_wdata;
  slot_entry_t       ram_rdata;
  logic [ENTRY_W-1:0] ram_rdata_raw;

  logic   rsp_valid;
  rsp_t   rsp;
  logic   out_hold;

  logic   out_valid_q;
  rsp_t   out_data_q;

  rsfl_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (NUM_SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata_raw)
  );

  assign ram_rdata = slot_entry_t'(ram_rdata_raw);

  // The sequencer reads the slot at accept, then decides and writes back.
  // A finished result waits in the output register; the next transfer is
  // accepted meanwhile and only its write-back waits for the register to free.
  rsfl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_hold_i  (out_hold),
    .rsp_valid_o (rsp_valid),
    .rsp_o       (rsp),
    .ram_re_o    (ram_re),
    .ram_raddr_o (ram_raddr),
    .ram_we_o    (ram_we),
    .ram_waddr_o (ram_waddr),
    .ram_wdata_o (ram_wdata),
    .ram_rdata_i (ram_rdata)
  );

  assign out_hold = out_valid_q && out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (!out_hold) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_valid && !out_hold) begin
      out_data_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

FILE: hw/rtl/rsfl_checker.sv
module rsfl_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input rsfl_pkg::req_t in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input rsfl_pkg::rsp_t out_data_o
);
  import rsfl_pkg::*;

  // One operation in flight: a transfer blocks the input for the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input accepted on back-to-back cycles");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // Failed operations return zero id and data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status != STAT_OK |->
      out_data_o.new_id == '0 && out_data_o.read_data == '0)
    else $error("failed operation returned payload");

  // Full only when every slot is in use.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == STAT_FULL |->
      out_data_o.active_count == CNT_W'(NUM_SLOTS))
    else $error("store full with free slots");

endmodule

bind record_slot_store_free_list_core rsfl_checker u_rsfl_checker (.*);
